// ----- design/smalu_pkg.sv -----
package smalu_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int RES_W  = 35;
    localparam int POS_W  = 3;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_PUSH
    } seq_state_t;

    // One step handed to the shared unit, tagged at read-issue time
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [1:0] op;
    } mac_ctrl_t;

endpackage

// ----- design/smalu_ram.sv -----
module smalu_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [ADDR_W-1:0]                wr_addr,
    input  logic [smalu_pkg::ELEM_W-1:0]     wr_data,
    input  logic [ADDR_W-1:0]                rd_addr,
    output logic [smalu_pkg::ELEM_W-1:0]     rd_data
);

    logic [smalu_pkg::ELEM_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/smalu_mac.sv -----
module smalu_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  smalu_pkg::mac_ctrl_t              ctrl,
    input  logic [smalu_pkg::ELEM_W-1:0]      a_data,
    input  logic [smalu_pkg::ELEM_W-1:0]      b_data,
    output logic [smalu_pkg::RES_W-1:0]       acc,
    output logic                              done
);

    smalu_pkg::mac_ctrl_t c1_reg, c2_reg;
    logic signed [smalu_pkg::RES_W-1:0] prod_reg, prod_next;
    logic        [smalu_pkg::RES_W-1:0] acc_reg, acc_next;
    logic done_reg;

    logic signed [smalu_pkg::ELEM_W-1:0] a_s, b_s;
    logic signed [smalu_pkg::PROD_W-1:0] mul_w;
    logic signed [smalu_pkg::ELEM_W:0]   sum_w, dif_w;

    assign a_s   = a_data;
    assign b_s   = b_data;
    assign mul_w = a_s * b_s;
    assign sum_w = {a_s[smalu_pkg::ELEM_W-1], a_s} + {b_s[smalu_pkg::ELEM_W-1], b_s};
    assign dif_w = {a_s[smalu_pkg::ELEM_W-1], a_s} - {b_s[smalu_pkg::ELEM_W-1], b_s};

    // Shared unit: sums and differences come out scaled by 256
    always_comb begin
        case (c1_reg.op)
            smalu_pkg::OP_ADD:
                prod_next = {{(smalu_pkg::RES_W - smalu_pkg::ELEM_W - 9){sum_w[smalu_pkg::ELEM_W]}},
                             sum_w, 8'd0};
            smalu_pkg::OP_SUB:
                prod_next = {{(smalu_pkg::RES_W - smalu_pkg::ELEM_W - 9){dif_w[smalu_pkg::ELEM_W]}},
                             dif_w, 8'd0};
            default:
                prod_next = {{(smalu_pkg::RES_W - smalu_pkg::PROD_W){mul_w[smalu_pkg::PROD_W-1]}},
                             mul_w};
        endcase
    end

    always_comb begin
        acc_next = acc_reg;
        if (c2_reg.valid) begin
            acc_next = c2_reg.first ? prod_reg : acc_reg + prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg   <= '0;
            c2_reg   <= '0;
            done_reg <= 1'b0;
        end else begin
            c1_reg   <= ctrl;
            c2_reg   <= c1_reg;
            done_reg <= c2_reg.valid & c2_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (c1_reg.valid) begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ----- design/small_matrix_alu_top.sv -----
// Channel   Dir  Handshake            Payload
// s_ (load) in   s_tvalid/s_tready    tdata: element_value; tuser: target_matrix
// m_ (res)  out  m_tvalid/m_tready    tdata: result_value,row,col; tlast: last_result
// APB cfg   in   psel/penable/pready  0x0 operation, 0x4 active_size
//
// Cycles: one per A beat or non-final B beat. The final B beat starts the result pass:
// each element is issued to the one shared unit (n steps for a product), then read,
// multiplied, added or subtracted, accumulated and pushed; s_tready stays low
// for the whole pass.
// Reset: aresetn is synchronous, active low; the element stores are not cleared.
// Stalls: a held result waits in the output register; the sequencer holds in push.
module small_matrix_alu_top #(
    parameter int MAX_DIM = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // load channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] element_value
    input  logic [0:0]  s_tuser,   // [0] target_matrix
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [34:0] result_value, [37:35] row, [40:38] col
    output logic        m_tlast,   // last_result
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int N_W    = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = N_W + 1;
    localparam logic REG_OPERATION = 1'b0;
    localparam logic REG_SIZE      = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0] operation_reg;
    logic [3:0] size_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operation_reg <= smalu_pkg::OP_MUL;
            size_reg      <= 4'd5;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_OPERATION: operation_reg <= pwdata[1:0];
                REG_SIZE:      size_reg      <= pwdata[3:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_OPERATION: prdata = {30'd0, operation_reg};
            REG_SIZE:      prdata = {28'd0, size_reg};
            default:       prdata = '0;
        endcase
    end

    // Clamp the size: zero acts as one, anything past MAX_DIM as MAX_DIM
    logic [N_W-1:0]   n;
    logic [CNT_W-1:0] total;
    logic             is_mul;

    always_comb begin
        if (size_reg == 4'd0) begin
            n = N_W'(1);
        end else if (32'(size_reg) > MAX_DIM) begin
            n = N_W'(MAX_DIM);
        end else begin
            n = N_W'(size_reg);
        end
    end

    assign total  = CNT_W'(n) * CNT_W'(n);
    assign is_mul = (operation_reg != smalu_pkg::OP_ADD) &&
                    (operation_reg != smalu_pkg::OP_SUB);

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    smalu_pkg::seq_state_t state_reg, state_next;
    logic [CNT_W-1:0] loaded_a_reg, loaded_a_next;
    logic [CNT_W-1:0] loaded_b_reg, loaded_b_next;
    logic [DIM_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0] row_base_reg, row_base_next, kn_reg, kn_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [smalu_pkg::RES_W-1:0] m_value_reg;
    logic [smalu_pkg::POS_W-1:0] m_row_reg, m_col_reg;
    logic             m_last_reg;

    logic             load_fire, load_a, load_b;
    logic [CNT_W-1:0] a_wr_cnt, b_wr_cnt, b_cnt_inc;
    logic             b_complete;
    logic             last_k, last_j, last_i, out_free, push;
    logic [IDX_W-1:0] a_rd_addr, b_rd_addr, elem_idx;
    logic [smalu_pkg::ELEM_W-1:0] a_rd_data, b_rd_data;
    logic [smalu_pkg::RES_W-1:0]  mac_acc;
    logic             mac_done;
    smalu_pkg::mac_ctrl_t mac_ctrl;

    assign s_tready  = (state_reg == smalu_pkg::ST_IDLE);
    assign load_fire = s_tvalid & s_tready;
    assign load_a    = load_fire & ~s_tuser[0];
    assign load_b    = load_fire &  s_tuser[0];

    // A full matrix restarts at element 0
    assign a_wr_cnt   = (loaded_a_reg >= total) ? '0 : loaded_a_reg;
    assign b_wr_cnt   = (loaded_b_reg >= total) ? '0 : loaded_b_reg;
    assign b_cnt_inc  = b_wr_cnt + CNT_W'(1);
    assign b_complete = load_b && (b_cnt_inc == total);

    assign last_k   = !is_mul || ((CMP_W'(k_reg) + CMP_W'(1)) == CMP_W'(n));
    assign last_j   = (CMP_W'(j_reg) + CMP_W'(1)) == CMP_W'(n);
    assign last_i   = (CMP_W'(i_reg) + CMP_W'(1)) == CMP_W'(n);
    assign out_free = !m_tvalid_reg || m_tready;
    assign push     = (state_reg == smalu_pkg::ST_PUSH) && out_free;

    assign elem_idx  = row_base_reg + IDX_W'(j_reg);
    assign a_rd_addr = is_mul ? row_base_reg + IDX_W'(k_reg) : elem_idx;
    assign b_rd_addr = is_mul ? kn_reg + IDX_W'(j_reg) : elem_idx;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smalu_pkg::ST_IDLE:  if (b_complete) state_next = smalu_pkg::ST_ISSUE;
            smalu_pkg::ST_ISSUE: if (last_k) state_next = smalu_pkg::ST_WAIT;
            smalu_pkg::ST_WAIT:  if (mac_done) state_next = smalu_pkg::ST_PUSH;
            smalu_pkg::ST_PUSH: begin
                if (out_free) begin
                    state_next = (last_i && last_j) ? smalu_pkg::ST_IDLE
                                                    : smalu_pkg::ST_ISSUE;
                end
            end
            default:             state_next = smalu_pkg::ST_IDLE;
        endcase
    end

    // Counters, indices and the step handed to the shared unit
    always_comb begin
        loaded_a_next = loaded_a_reg;
        loaded_b_next = loaded_b_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        row_base_next = row_base_reg;
        kn_next       = kn_reg;
        mac_ctrl      = '0;
        case (state_reg)
            smalu_pkg::ST_IDLE: begin
                if (load_a) begin
                    loaded_a_next = a_wr_cnt + CNT_W'(1);
                end
                if (load_b) begin
                    loaded_b_next = b_cnt_inc;
                end
                if (b_complete) begin
                    // both matrices start over once the results go out
                    loaded_a_next = '0;
                    loaded_b_next = '0;
                    i_next        = '0;
                    j_next        = '0;
                    k_next        = '0;
                    row_base_next = '0;
                    kn_next       = '0;
                end
            end
            smalu_pkg::ST_ISSUE: begin
                mac_ctrl.valid = 1'b1;
                mac_ctrl.first = (k_reg == '0);
                mac_ctrl.last  = last_k;
                mac_ctrl.op    = operation_reg;
                if (last_k) begin
                    k_next  = '0;
                    kn_next = '0;
                end else begin
                    k_next  = k_reg + DIM_W'(1);
                    kn_next = kn_reg + IDX_W'(n);
                end
            end
            smalu_pkg::ST_PUSH: begin
                if (out_free) begin
                    if (last_j) begin
                        j_next        = '0;
                        i_next        = i_reg + DIM_W'(1);
                        row_base_next = row_base_reg + IDX_W'(n);
                    end else begin
                        j_next = j_reg + DIM_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register: load on push, drop on take
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (push) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= smalu_pkg::ST_IDLE;
            loaded_a_reg <= '0;
            loaded_b_reg <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            row_base_reg <= '0;
            kn_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            loaded_a_reg <= loaded_a_next;
            loaded_b_reg <= loaded_b_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            row_base_reg <= row_base_next;
            kn_reg       <= kn_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_value_reg <= mac_acc;
            m_row_reg   <= smalu_pkg::POS_W'(i_reg);
            m_col_reg   <= smalu_pkg::POS_W'(j_reg);
            m_last_reg  <= last_i && last_j;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_col_reg, m_row_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Element stores and the shared arithmetic unit
    // ------------------------------------------------------------------
    smalu_ram #(.DEPTH(CELLS), .ADDR_W(IDX_W)) u_store_a (
        .aclk    (aclk),
        .wr_en   (load_a),
        .wr_addr (a_wr_cnt[IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    smalu_ram #(.DEPTH(CELLS), .ADDR_W(IDX_W)) u_store_b (
        .aclk    (aclk),
        .wr_en   (load_b),
        .wr_addr (b_wr_cnt[IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    smalu_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .a_data  (a_rd_data),
        .b_data  (b_rd_data),
        .acc     (mac_acc),
        .done    (mac_done)
    );

endmodule
